// ----- rtl/core/rei_pkg.sv -----
// ----------------------------------------------------------------------------
// rei_pkg: shared types and constants of the read error injector
// Action codes, character codes and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rei_pkg;

	typedef enum logic [1:0] {
		ACT_SEED = 2'd0,
		ACT_BASE = 2'd1,
		ACT_POS  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	localparam logic [7:0] CHAR_N_UP = 8'h4E;
	localparam logic [7:0] CHAR_N_LO = 8'h6E;
	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam logic [7:0] CHAR_C    = 8'h43;
	localparam logic [7:0] CHAR_G    = 8'h47;
	localparam logic [7:0] CHAR_T    = 8'h54;

	localparam logic [31:0] DIVISOR_RESET = 32'd100;
	localparam logic [31:0] SEED_ONE      = 32'd1;

	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	// How the working result is loaded.
	typedef enum logic [2:0] {
		RES_ZERO    = 3'd0,
		RES_PASS    = 3'd1,
		RES_INVALID = 3'd2,
		RES_POS     = 3'd3,
		RES_SUB     = 3'd4
	} res_sel_t;

	typedef struct packed {
		logic     capture;     // latch the accepted item
		logic     load_seed;   // replace the generator state
		logic     step_prng;   // advance the generator once
		logic     div_load;    // start a division of the new draw
		logic     div_by_len;  // divisor is the reference length
		logic     div_step;    // one restoring division step
		logic     set_res;     // load the working result
		res_sel_t res_sel;
		logic     emit;        // move the working result to the output
	} rei_cmd_t;

	typedef struct packed {
		action_t action;
		logic    is_n;       // captured base is N or n
		logic    len_zero;   // captured reference length is zero
		logic    div_last;   // current division step is the last
		logic    rem_zero;   // division remainder is zero
		logic    pick_ok;    // substitute letter differs from the base
		logic    out_busy;   // output register holds an untaken result
	} rei_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/rei_req_if.sv -----
// ----------------------------------------------------------------------------
// rei_req_if: input item channel
// Valid/ready channel carrying one request item of the error injector.
// ----------------------------------------------------------------------------
`default_nettype none

interface rei_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] seed_value;
	logic [7:0]  base_in;
	logic [31:0] ref_length;

	modport source (output valid, action, seed_value, base_in, ref_length, input ready);
	modport sink   (input valid, action, seed_value, base_in, ref_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rei_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rei_rsp_if: result item channel
// Valid/ready channel carrying one result item of the error injector.
// ----------------------------------------------------------------------------
`default_nettype none

interface rei_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  base_out;
	logic        mutated;
	logic        invalid_base;
	logic [31:0] start_position;

	modport source (output valid, base_out, mutated, invalid_base, start_position,
		input ready);
	modport sink   (input valid, base_out, mutated, invalid_base, start_position,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/core/read_error_injector.sv -----
// ----------------------------------------------------------------------------
// read_error_injector: substitution error model for simulated reads
// Xorshift generator with seed load, position draw and base substitution.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (valid/ready); one result leaves on rsp for every
//   request. error_divisor is written through cfg_we/cfg_wdata; the user must
//   write it only while idle, the block itself does not enforce this.
//   Seed load, unused action, N/n base and zero reference length go from
//   decode straight to the finish state; position draw and unmutated base
//   first pass through the 32 steps of the bit-serial restoring divider;
//   a mutated base then takes k >= 1 substitute draws of the picker.
//   One request is in progress at a time and req.ready is high only while
//   idle, so a new request is taken only once the last has left finish.
//   A finished result sits in the output register; the next request is
//   taken while it waits, and that request completes only after rsp has
//   transferred the earlier one. While rsp.ready is low the output holds.
//   Reset sets the generator state to one, error_divisor to 100 and empties
//   the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module read_error_injector
	import rei_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	rei_req_if.sink          req,
	rei_rsp_if.source        rsp,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);

	rei_cmd_t    cmd;
	rei_status_t status;

	rei_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	rei_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_action    (req.action),
		.in_seed      (req.seed_value),
		.in_base      (req.base_in),
		.in_len       (req.ref_length),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_base     (rsp.base_out),
		.out_mutated  (rsp.mutated),
		.out_invalid  (rsp.invalid_base),
		.out_position (rsp.start_position)
	);

endmodule

`default_nettype wire

// ----- rtl/core/rei_dp.sv -----
// ----------------------------------------------------------------------------
// rei_dp: error injector datapath
// Generator state, configuration register, item registers, iterative
// restoring divider, substitute picker and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rei_dp
	import rei_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rei_cmd_t    cmd,
	output rei_status_t      status,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic [1:0]  in_action,
	input  wire logic [31:0] in_seed,
	input  wire logic [7:0]  in_base,
	input  wire logic [31:0] in_len,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_base,
	output logic             out_mutated,
	output logic             out_invalid,
	output logic [31:0]      out_position
);

	logic [31:0] prng_q;
	logic [31:0] err_div_q;
	logic [1:0]  action_q;
	logic [31:0] seed_q;
	logic [7:0]  base_q;
	logic [31:0] len_q;

	logic [31:0]      rem_q;
	logic [31:0]      dvd_q;
	logic [31:0]      dvs_q;
	logic [CNT_W-1:0] cnt_q;

	logic [7:0]  res_base_q;
	logic        res_mut_q;
	logic        res_inv_q;
	logic [31:0] res_pos_q;
	logic        out_valid_q;

	logic [31:0] prng_next;
	logic [31:0] sh1;
	logic [31:0] sh2;
	logic [32:0] trial;
	logic [32:0] diff;
	logic [7:0]  letter;
	logic [31:0] div_sel;

	always_comb begin
		sh1       = prng_q ^ (prng_q << 13);
		sh2       = sh1 ^ (sh1 >> 17);
		prng_next = sh2 ^ (sh2 << 15);
	end

	always_comb begin
		unique case (prng_next[1:0])
			2'd0: letter = CHAR_A;
			2'd1: letter = CHAR_C;
			2'd2: letter = CHAR_G;
			default: letter = CHAR_T;
		endcase
	end

	// A zero divisor behaves as one.
	always_comb begin
		if (cmd.div_by_len) begin
			div_sel = len_q;
		end else if (err_div_q == 32'd0) begin
			div_sel = SEED_ONE;
		end else begin
			div_sel = err_div_q;
		end
	end

	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prng_q      <= SEED_ONE;
			err_div_q   <= DIVISOR_RESET;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				err_div_q <= cfg_wdata;
			end
			if (cmd.load_seed) begin
				prng_q <= (seed_q == 32'd0) ? SEED_ONE : seed_q;
			end else if (cmd.step_prng) begin
				prng_q <= prng_next;
			end
			if (cmd.div_load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			seed_q   <= in_seed;
			base_q   <= in_base;
			len_q    <= in_len;
		end
		if (cmd.div_load) begin
			rem_q <= '0;
			dvd_q <= prng_next;
			dvs_q <= div_sel;
		end else if (cmd.div_step) begin
			// The partial remainder stays below twice the divisor.
			rem_q <= diff[32] ? trial[31:0] : diff[31:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
		end
		if (cmd.set_res) begin
			unique case (cmd.res_sel)
				RES_PASS: begin
					res_base_q <= base_q;
					res_mut_q  <= 1'b0;
					res_inv_q  <= 1'b0;
					res_pos_q  <= '0;
				end
				RES_INVALID: begin
					res_base_q <= base_q;
					res_mut_q  <= 1'b0;
					res_inv_q  <= 1'b1;
					res_pos_q  <= '0;
				end
				RES_POS: begin
					res_base_q <= '0;
					res_mut_q  <= 1'b0;
					res_inv_q  <= 1'b0;
					res_pos_q  <= rem_q;
				end
				RES_SUB: begin
					res_base_q <= letter;
					res_mut_q  <= 1'b1;
					res_inv_q  <= 1'b0;
					res_pos_q  <= '0;
				end
				default: begin
					res_base_q <= '0;
					res_mut_q  <= 1'b0;
					res_inv_q  <= 1'b0;
					res_pos_q  <= '0;
				end
			endcase
		end
		if (cmd.emit) begin
			out_base     <= res_base_q;
			out_mutated  <= res_mut_q;
			out_invalid  <= res_inv_q;
			out_position <= res_pos_q;
		end
	end

	assign status.action   = action_t'(action_q);
	assign status.is_n     = (base_q == CHAR_N_UP) || (base_q == CHAR_N_LO);
	assign status.len_zero = (len_q == 32'd0);
	assign status.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign status.rem_zero = (rem_q == 32'd0);
	assign status.pick_ok  = (letter != base_q);
	assign status.out_busy = out_valid_q & ~out_ready;

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/rei_ctrl.sv -----
// ----------------------------------------------------------------------------
// rei_ctrl: error injector controller
// Sequences one item at a time: decode, division, substitute picking and
// hand-off of the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rei_ctrl
	import rei_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire rei_status_t status,
	output rei_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_DECIDE,
		ST_PICK,
		ST_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.res_sel = RES_ZERO;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
			end
			ST_DECODE: begin
				unique case (status.action)
					ACT_SEED: begin
						cmd.load_seed = 1'b1;
						cmd.set_res   = 1'b1;
					end
					ACT_BASE: begin
						if (status.is_n) begin
							cmd.set_res = 1'b1;
							cmd.res_sel = RES_INVALID;
						end else begin
							cmd.step_prng = 1'b1;
							cmd.div_load  = 1'b1;
						end
					end
					ACT_POS: begin
						cmd.step_prng  = 1'b1;
						cmd.div_by_len = 1'b1;
						if (status.len_zero) begin
							cmd.set_res = 1'b1;
						end else begin
							cmd.div_load = 1'b1;
						end
					end
					default: begin
						cmd.set_res = 1'b1;
					end
				endcase
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_DECIDE: begin
				if (status.action == ACT_POS) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = RES_POS;
				end else if (!status.rem_zero) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = RES_PASS;
				end
			end
			ST_PICK: begin
				cmd.step_prng = 1'b1;
				cmd.set_res   = status.pick_ok;
				cmd.res_sel   = RES_SUB;
			end
			ST_FINISH: begin
				cmd.emit = ~status.out_busy;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (cmd.div_load) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_DIV: begin
					if (status.div_last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (status.action == ACT_BASE && status.rem_zero) begin
						state_q <= ST_PICK;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_PICK: begin
					if (status.pick_ok) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rei_checker.sv -----
// ----------------------------------------------------------------------------
// rei_checker: port-level checks of the read error injector
// Watches the result channel and checks consistency of the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rei_checker
	import rei_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [7:0]  rsp_base_out,
	input wire logic        rsp_mutated,
	input wire logic        rsp_invalid_base,
	input wire logic [31:0] rsp_start_position
);

	// A stalled result stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn while stalled");

	// A substituted base is always one of A, C, G or T.
	a_sub_letter: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_mutated |-> (rsp_base_out == CHAR_A || rsp_base_out == CHAR_C
			|| rsp_base_out == CHAR_G || rsp_base_out == CHAR_T))
		else $error("substitute is not a nucleotide");

	// An invalid base is passed through unchanged and never mutated.
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_invalid_base |-> !rsp_mutated
			&& (rsp_base_out == CHAR_N_UP || rsp_base_out == CHAR_N_LO))
		else $error("invalid base result is inconsistent");

	// A position result carries no base information.
	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_start_position != 32'd0 |-> rsp_base_out == 8'd0
			&& !rsp_mutated && !rsp_invalid_base)
		else $error("position result carries base fields");

endmodule

bind read_error_injector rei_checker u_rei_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_base_out       (rsp.base_out),
	.rsp_mutated        (rsp.mutated),
	.rsp_invalid_base   (rsp.invalid_base),
	.rsp_start_position (rsp.start_position)
);

`default_nettype wire
